[design/mag_minmax_calibrate_normalize_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the magnetometer calibrate/normalize core
// Concurrent implication checks, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MAG_MINMAX_CALIBRATE_NORMALIZE_CORE_MACROS_SVH
`define MAG_MINMAX_CALIBRATE_NORMALIZE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define MMCN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MMCN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MMCN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MMCN_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/mmcn_pkg.sv]
// ----------------------------------------------------------------------------
// mmcn_pkg
// Shared types and constants of the magnetometer calibrate/normalize core.
// ----------------------------------------------------------------------------
`default_nettype none
package mmcn_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int AXES          = 3;
    localparam int VFRAC         = 24;   // axis value fraction bits
    localparam int MAG_W         = 25;   // |axis value| and length width
    localparam int DIVD_W        = 2 * MAG_W;
    localparam int STEPS         = MAG_W; // iterations of each serial unit
    localparam int CNT_W         = 5;

    localparam logic [7:0] STATUS_DRDY = 8'h08;
    localparam logic [7:0] STATUS_OVR  = 8'h80;

    typedef enum logic [1:0] {
        RC_NO_DATA = 2'd0,
        RC_UNCAL   = 2'd1,
        RC_VALID   = 2'd2,
        RC_ZERO    = 2'd3
    } res_code_t;

    typedef struct packed {
        res_code_t         code;
        logic [2:0]        neg;
        logic [2:0][15:0]  nmag;
        logic [2:0][15:0]  range;
    } mmcn_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_LOAD_AX,
        S_DIV_AX,
        S_LOAD_MUL,
        S_MUL,
        S_LOAD_SQRT,
        S_SQRT,
        S_CHECK,
        S_LOAD_DIR,
        S_DIV_DIR,
        S_OUT
    } back_state_t;

endpackage
`default_nettype wire

[design/mmcn_front.sv]
// ----------------------------------------------------------------------------
// mmcn_front
// Accepts samples, tracks per-axis bounds and classifies each transfer.
// ----------------------------------------------------------------------------
`default_nettype none
module mmcn_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           sensor_status,
    input  wire logic signed [15:0]   sample_x,
    input  wire logic signed [15:0]   sample_y,
    input  wire logic signed [15:0]   sample_z,
    input  wire mmcn_pkg::fifo_stat_t fifo_stat,
    output logic                      push,
    output mmcn_pkg::mmcn_item_t      push_item
);
    import mmcn_pkg::*;

    logic signed [15:0] min_reg  [AXES];
    logic signed [15:0] max_reg  [AXES];
    logic signed [15:0] min_next [AXES];
    logic signed [15:0] max_next [AXES];
    logic signed [15:0] samp     [AXES];
    logic signed [17:0] rng, dif, num, nabs;
    logic               has_data, cal;

    assign in_stall = fifo_stat.full;
    assign push     = in_valid && !fifo_stat.full;

    always_comb
    begin
        samp[0]  = sample_x;
        samp[1]  = sample_y;
        samp[2]  = sample_z;
        has_data = (sensor_status & (STATUS_DRDY | STATUS_OVR)) != 8'd0;
        cal      = 1'b1;
        rng      = '0;
        dif      = '0;
        num      = '0;
        nabs     = '0;
        push_item = '0;
        for (int a = 0; a < AXES; a++)
        begin
            min_next[a] = (samp[a] < min_reg[a]) ? samp[a] : min_reg[a];
            max_next[a] = (samp[a] > max_reg[a]) ? samp[a] : max_reg[a];
            rng  = 18'(max_next[a]) - 18'(min_next[a]);
            dif  = 18'(samp[a]) - 18'(min_next[a]);
            num  = (dif <<< 1) - rng;
            nabs = num[17] ? -num : num;
            push_item.neg[a]   = num[17];
            push_item.nmag[a]  = nabs[15:0];
            push_item.range[a] = rng[15:0];
            cal = cal && (min_next[a] < max_next[a]) &&
                  (min_next[a] != 16'sd0) && (max_next[a] != 16'sd0);
        end
        if (!has_data)
            push_item.code = RC_NO_DATA;
        else if (!cal)
            push_item.code = RC_UNCAL;
        else
            push_item.code = RC_VALID;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                min_reg[a] <= '0;
                max_reg[a] <= '0;
            end
        end
        else if (push && has_data)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                min_reg[a] <= min_next[a];
                max_reg[a] <= max_next[a];
            end
        end
    end

endmodule
`default_nettype wire

[design/mmcn_fifo.sv]
// ----------------------------------------------------------------------------
// mmcn_fifo
// Two-entry queue between the classifier and the arithmetic sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module mmcn_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire mmcn_pkg::mmcn_item_t push_item,
    input  wire logic                 pop,
    output mmcn_pkg::mmcn_item_t      pop_item,
    output mmcn_pkg::fifo_stat_t      stat
);
    import mmcn_pkg::*;

    mmcn_item_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign pop_item   = mem_reg[rd_ptr_reg];
    assign stat.full  = count_reg == 2'd2;
    assign stat.empty = count_reg == 2'd0;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

[design/mmcn_back.sv]
// ----------------------------------------------------------------------------
// mmcn_back
// Serial divider, multiplier and square root that turn an item into a result.
// ----------------------------------------------------------------------------
`default_nettype none
module mmcn_back #(
    parameter int FRAC_BITS = mmcn_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mmcn_pkg::fifo_stat_t fifo_stat,
    output logic                      pop,
    input  wire mmcn_pkg::mmcn_item_t pop_item,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                result_code,
    output logic signed [15:0]        dir_x,
    output logic signed [15:0]        dir_y,
    output logic signed [15:0]        dir_z
);
    import mmcn_pkg::*;

    localparam logic [MAG_W:0]   ONE_W = (MAG_W + 1)'(1) << FRAC_BITS;
    localparam logic [MAG_W-1:0] LIM   = ONE_W[MAG_W-1:0];
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(STEPS - 1);

    back_state_t       state_reg, state_next;
    mmcn_item_t        item_reg;
    res_code_t         code_reg;
    logic [1:0]        ax_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              out_load, last_step, slot_free;

    // divider
    logic [MAG_W-1:0]  rem_reg, dq_reg, dvs_reg;
    logic [MAG_W:0]    trial;
    logic              ge;
    logic [MAG_W-1:0]  rem_step, dq_step, q_sat;
    logic [MAG_W:0]    q_signed;
    logic [DIVD_W-1:0] dividend;

    // multiplier and square root
    logic [MAG_W-1:0]  vmag_reg [AXES];
    logic [DIVD_W-1:0] acc_reg, ma_reg, sv_reg, sres_reg, sbit_reg, sq_trial;
    logic [MAG_W-1:0]  mb_reg, len;
    logic signed [15:0] dres_reg [AXES];
    logic              out_valid_reg;

    assign last_step = cnt_reg == LAST;
    assign slot_free = !out_valid_reg || !out_stall;
    assign len       = sres_reg[MAG_W-1:0];

    always_comb
    begin
        trial    = {rem_reg, dq_reg[MAG_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        rem_step = ge ? MAG_W'(trial - {1'b0, dvs_reg}) : trial[MAG_W-1:0];
        dq_step  = {dq_reg[MAG_W-2:0], ge};
        q_sat    = (dq_step > LIM) ? LIM : dq_step;
        q_signed = item_reg.neg[ax_reg] ? -{1'b0, q_sat} : {1'b0, q_sat};
        sq_trial = sres_reg + sbit_reg;
        if (state_reg == S_LOAD_AX)
            dividend = (DIVD_W'(item_reg.nmag[ax_reg]) << VFRAC)
                     + DIVD_W'(item_reg.range[ax_reg] >> 1);
        else
            dividend = (DIVD_W'(vmag_reg[ax_reg]) << FRAC_BITS) + DIVD_W'(len >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    pop        = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
                state_next = (item_reg.code == RC_VALID) ? S_LOAD_AX : S_OUT;
            S_LOAD_AX:
                state_next = S_DIV_AX;
            S_DIV_AX:
                if (last_step)
                    state_next = (ax_reg == 2'd2) ? S_LOAD_MUL : S_LOAD_AX;
            S_LOAD_MUL:
                state_next = S_MUL;
            S_MUL:
                if (last_step)
                    state_next = (ax_reg == 2'd2) ? S_LOAD_SQRT : S_LOAD_MUL;
            S_LOAD_SQRT:
                state_next = S_SQRT;
            S_SQRT:
                if (last_step)
                    state_next = S_CHECK;
            S_CHECK:
                state_next = (len == '0) ? S_OUT : S_LOAD_DIR;
            S_LOAD_DIR:
                state_next = S_DIV_DIR;
            S_DIV_DIR:
                if (last_step)
                    state_next = (ax_reg == 2'd2) ? S_OUT : S_LOAD_DIR;
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // sequencing counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg  <= 2'd0;
            cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_START:
                    ax_reg <= 2'd0;
                S_LOAD_AX, S_LOAD_MUL, S_LOAD_SQRT, S_LOAD_DIR:
                    cnt_reg <= '0;
                S_DIV_AX, S_MUL, S_DIV_DIR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (last_step)
                        ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                end
                S_SQRT:
                    cnt_reg <= cnt_reg + 1'b1;
                default:
                    cnt_reg <= cnt_reg;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= pop_item;
        case (state_reg)
            S_START:
            begin
                code_reg <= item_reg.code;
                acc_reg  <= '0;
                // uncalibrated items point along x
                for (int a = 0; a < AXES; a++)
                    dres_reg[a] <= (a == 0 && item_reg.code == RC_UNCAL) ?
                                   ONE_W[15:0] : '0;
            end
            S_LOAD_AX, S_LOAD_DIR:
            begin
                rem_reg <= dividend[DIVD_W-1:MAG_W];
                dq_reg  <= dividend[MAG_W-1:0];
                dvs_reg <= (state_reg == S_LOAD_AX) ? MAG_W'(item_reg.range[ax_reg]) : len;
            end
            S_DIV_AX, S_DIV_DIR:
            begin
                rem_reg <= rem_step;
                dq_reg  <= dq_step;
                if (last_step && state_reg == S_DIV_AX)
                    vmag_reg[ax_reg] <= dq_step;
                if (last_step && state_reg == S_DIV_DIR)
                    dres_reg[ax_reg] <= q_signed[15:0];
            end
            S_LOAD_MUL:
            begin
                ma_reg <= DIVD_W'(vmag_reg[ax_reg]);
                mb_reg <= vmag_reg[ax_reg];
            end
            S_MUL:
            begin
                if (mb_reg[0])
                    acc_reg <= acc_reg + ma_reg;
                ma_reg <= ma_reg << 1;
                mb_reg <= mb_reg >> 1;
            end
            S_LOAD_SQRT:
            begin
                sv_reg   <= acc_reg;
                sres_reg <= '0;
                sbit_reg <= DIVD_W'(1) << (DIVD_W - 2);
            end
            S_SQRT:
            begin
                if (sv_reg >= sq_trial)
                begin
                    sv_reg   <= sv_reg - sq_trial;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end
                else
                    sres_reg <= sres_reg >> 1;
                sbit_reg <= sbit_reg >> 2;
            end
            S_CHECK:
                if (len == '0)
                    code_reg <= RC_ZERO;
            default:
                code_reg <= code_reg;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_code <= code_reg;
            dir_x       <= dres_reg[0];
            dir_y       <= dres_reg[1];
            dir_z       <= dres_reg[2];
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

[design/mag_minmax_calibrate_normalize_core.sv]
// ----------------------------------------------------------------------------
// mag_minmax_calibrate_normalize_core
// Hard-iron min/max calibration and unit-vector normalizer for a magnetometer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries a status byte and a signed
//   x,y,z sample; a transfer happens when in_valid is high and in_stall low.
//   Every input transfer yields exactly one result transfer on the output
//   channel (out_valid/out_stall): result_code and dir_x/y/z in Q2.FRAC_BITS.
//   The front updates the running per-axis bounds in each transfer with data
//   and queues a classified item (two entries) for the arithmetic back end.
//   Items without new data or without calibration go from the start state
//   straight to the output; a zero-length vector stops after the square
//   root, and a valid direction takes 3 axis divisions, 3 squarings, one
//   square root and 3 direction divisions, each a serial unit after a load state.
//   The back end handles one item at a time and takes the next one only
//   after the last is in the output register; that sequencer sets throughput.
//   The front accepts while the queue has room.
//   Reset clears the bounds to zero, the queue and the output register.
//   A stalled result holds in the output register; the back end then waits
//   and the queue fills, after which in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mag_minmax_calibrate_normalize_core_macros.svh"
module mag_minmax_calibrate_normalize_core #(
    parameter int FRAC_BITS = mmcn_pkg::FRAC_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [7:0]          sensor_status,
    input  wire logic signed [15:0]  sample_x,
    input  wire logic signed [15:0]  sample_y,
    input  wire logic signed [15:0]  sample_z,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [1:0]               result_code,
    output logic signed [15:0]       dir_x,
    output logic signed [15:0]       dir_y,
    output logic signed [15:0]       dir_z
);
    import mmcn_pkg::*;

    fifo_stat_t fifo_stat;
    mmcn_item_t push_item, pop_item;
    logic       push, pop;

    // classifier and bound tracker
    mmcn_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sensor_status (sensor_status),
        .sample_x      (sample_x),
        .sample_y      (sample_y),
        .sample_z      (sample_z),
        .fifo_stat     (fifo_stat),
        .push          (push),
        .push_item     (push_item)
    );

    // decoupling queue
    mmcn_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (fifo_stat)
    );

    // serial arithmetic and output register
    mmcn_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_stat   (fifo_stat),
        .pop         (pop),
        .pop_item    (pop_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_code (result_code),
        .dir_x       (dir_x),
        .dir_y       (dir_y),
        .dir_z       (dir_z)
    );

    // the back end never pops an empty queue
    `MMCN_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, !fifo_stat.empty)
    // an accepted transfer is queued for the back end
    `MMCN_ASSERT_NXT(a_push_seen, clk, rst_n, in_valid && !in_stall, !fifo_stat.empty)
    // no-data and zero-length results carry a zero vector
    `MMCN_ASSERT_IMP(a_zero_dir, clk, rst_n,
        out_valid && (result_code == RC_NO_DATA || result_code == RC_ZERO),
        dir_x == 16'sd0 && dir_y == 16'sd0 && dir_z == 16'sd0)
    // uncalibrated results point along x only
    `MMCN_ASSERT_IMP(a_uncal_dir, clk, rst_n, out_valid && result_code == RC_UNCAL,
        dir_y == 16'sd0 && dir_z == 16'sd0)

endmodule
`default_nettype wire

[test/mmcn_checker.sv]
// ----------------------------------------------------------------------------
// mmcn_checker
// Watches both channels of the calibrate/normalize core, predicts each result
// from the accepted samples, and compares the results in order.
// ----------------------------------------------------------------------------
`default_nettype none
module mmcn_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [7:0]         sensor_status,
    input  wire logic signed [15:0] sample_x,
    input  wire logic signed [15:0] sample_y,
    input  wire logic signed [15:0] sample_z,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [1:0]         result_code,
    input  wire logic signed [15:0] dir_x,
    input  wire logic signed [15:0] dir_y,
    input  wire logic signed [15:0] dir_z,
    output int                      sample_count,
    output int                      pending,
    output int                      errors
);
    timeunit 1ns;
    timeprecision 1ps;
    import mmcn_pkg::*;

    localparam int F = FRAC_BITS_DEF;

    typedef struct {
        res_code_t   code;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dz;
    } heading_t;

    heading_t headings_due[$];
    logic signed [15:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;

    // axis value in Q1.24, ties away from zero
    function automatic longint axis_q24(longint s, longint lo, longint hi);
        longint rng, num;
        longint unsigned mag, q;
        begin
            rng = hi - lo;
            num = 2 * (s - lo) - rng;
            mag = (num < 0) ? -num : num;
            q = ((mag << VFRAC) + rng / 2) / rng;
            return (num < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        begin
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        end
    endfunction

    function automatic logic [15:0] unit_comp(longint v, longint unsigned len);
        longint unsigned mag, q;
        longint r;
        begin
            mag = (v < 0) ? -v : v;
            q = ((mag << F) + len / 2) / len;
            if (q > (64'd1 << F)) q = 64'd1 << F;
            r = (v < 0) ? -longint'(q) : longint'(q);
            return r[15:0];
        end
    endfunction

    // updates the bounds and returns the expected heading
    function automatic heading_t predict_heading(logic [7:0] st, logic signed [15:0] x,
                                                 logic signed [15:0] y,
                                                 logic signed [15:0] z);
        heading_t h;
        longint vx, vy, vz;
        longint unsigned len;
        logic [63:0] one;
        begin
            h = '{RC_NO_DATA, 16'd0, 16'd0, 16'd0};
            if ((st & (STATUS_DRDY | STATUS_OVR)) == 8'd0) return h;
            if (x < lo_x) lo_x = x;
            if (y < lo_y) lo_y = y;
            if (z < lo_z) lo_z = z;
            if (x > hi_x) hi_x = x;
            if (y > hi_y) hi_y = y;
            if (z > hi_z) hi_z = z;
            if (!(lo_x < hi_x && lo_y < hi_y && lo_z < hi_z && lo_x != 0 && hi_x != 0 &&
                  lo_y != 0 && hi_y != 0 && lo_z != 0 && hi_z != 0)) begin
                one = 64'd1 << F;
                h.code = RC_UNCAL;
                h.dx = one[15:0];
                return h;
            end
            vx = axis_q24(x, lo_x, hi_x);
            vy = axis_q24(y, lo_y, hi_y);
            vz = axis_q24(z, lo_z, hi_z);
            len = int_sqrt(vx * vx + vy * vy + vz * vz);
            if (len == 0) begin
                h.code = RC_ZERO;
                return h;
            end
            h.code = RC_VALID;
            h.dx = unit_comp(vx, len);
            h.dy = unit_comp(vy, len);
            h.dz = unit_comp(vz, len);
            return h;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        heading_t h;
        if (!rst_n) begin
            lo_x = 0; lo_y = 0; lo_z = 0;
            hi_x = 0; hi_y = 0; hi_z = 0;
            headings_due.delete();
            sample_count <= 0;
            pending <= 0;
            errors <= 0;
        end else begin
            // result side first: latency is never zero
            if (out_valid && !out_stall) begin
                if (headings_due.size() == 0) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("unexpected result code=%0d dir=%0d,%0d,%0d",
                                 result_code, dir_x, dir_y, dir_z);
                end else begin
                    h = headings_due.pop_front();
                    if (result_code !== h.code || dir_x !== h.dx || dir_y !== h.dy ||
                        dir_z !== h.dz) begin
                        errors <= errors + 1;
                        if (errors < 10)
                            $display("exp code=%0d dir=%0d,%0d,%0d got code=%0d dir=%0d,%0d,%0d",
                                     h.code, $signed(h.dx), $signed(h.dy), $signed(h.dz),
                                     result_code, dir_x, dir_y, dir_z);
                    end
                end
            end
            if (in_valid && !in_stall) begin
                headings_due.push_back(predict_heading(sensor_status, sample_x, sample_y,
                                                       sample_z));
                sample_count <= sample_count + 1;
            end
            pending <= headings_due.size();
        end
    end
endmodule
`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives samples into the calibrate/normalize core with random gaps and
// output stalls, a long output hold and a full drain; the checker does the
// prediction and comparison, this top gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mmcn_pkg::*;

    localparam int N_RANDOM    = 1725;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_HOLD   = 800;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         sensor_status = 8'd0;
    logic signed [15:0] sample_x = 16'sd0;
    logic signed [15:0] sample_y = 16'sd0;
    logic signed [15:0] sample_z = 16'sd0;
    logic               out_valid;
    logic               out_stall = 1'b1;
    logic [1:0]         result_code;
    logic signed [15:0] dir_x, dir_y, dir_z;

    int sample_count, pending, errors;
    int cycles = 0;
    bit gaps_on = 1'b1;        // sender gaps between transfers
    bit stalls_on = 1'b1;      // receiver stalls between transfers
    bit hold_req = 1'b0;       // ask the receiver for one long hold

    mag_minmax_calibrate_normalize_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .sensor_status(sensor_status),
        .sample_x(sample_x), .sample_y(sample_y), .sample_z(sample_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_code(result_code), .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z)
    );

    mmcn_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .sensor_status(sensor_status),
        .sample_x(sample_x), .sample_y(sample_y), .sample_z(sample_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_code(result_code), .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .sample_count(sample_count), .pending(pending), .errors(errors)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("mag_minmax_calibrate_normalize_core: mismatch");
            $finish;
        end
    end

    // receiver: per-result random stall, plus one long hold on request
    initial begin
        int wait_left;
        int hold_left;
        wait_left = 0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (wait_left > 0) begin
                wait_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                // a transfer happens at the coming edge; draw the next wait
                if (out_valid && rst_n)
                    wait_left = stalls_on ? $urandom_range(0, 15) : 0;
            end
        end
    end

    // one transfer on the input channel, called at a falling edge
    task automatic send_sample(logic [7:0] st, logic signed [15:0] x,
                               logic signed [15:0] y, logic signed [15:0] z);
        int gap;
        int seen;
        begin
            gap = gaps_on ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            seen = sample_count;
            in_valid <= 1'b1;
            sensor_status <= st;
            sample_x <= x;
            sample_y <= y;
            sample_z <= z;
            do @(negedge clk); while (sample_count == seen);
        end
    endtask

    function automatic logic [7:0] data_status();
        logic [7:0] s;
        begin
            s = 8'($urandom);
            if ((s & (STATUS_DRDY | STATUS_OVR)) == 8'd0) s = s | STATUS_DRDY;
            return s;
        end
    endfunction

    function automatic logic signed [15:0] rand_axis();
        begin
            case ($urandom_range(0, 3))
                0: return 16'($urandom_range(0, 400)) - 16'sd200;
                1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                default: return 16'($urandom);
            endcase
        end
    endfunction

    initial begin
        int i;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: no data, not yet calibrated, zero length, extremes
        send_sample(8'h00, 16'sd100, -16'sd100, 16'sd5);
        send_sample(8'h77, -16'sd1, 16'sd1, 16'sd0);
        send_sample(STATUS_DRDY, 16'sd5, 16'sd5, 16'sd5);
        send_sample(STATUS_DRDY, -16'sd100, -16'sd100, -16'sd100);
        send_sample(STATUS_OVR, 16'sd100, 16'sd100, 16'sd100);
        send_sample(STATUS_DRDY, 16'sd0, 16'sd0, 16'sd0);
        send_sample(8'hff, 16'sd0, 16'sd0, 16'sd0);
        send_sample(STATUS_DRDY, 16'sd50, -16'sd25, 16'sd0);
        send_sample(STATUS_OVR, -16'sd100, 16'sd0, 16'sd100);
        send_sample(8'h00, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_sample(STATUS_DRDY, 16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(STATUS_DRDY, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_sample(STATUS_OVR, 16'sh8000, 16'sh7fff, 16'sd0);
        send_sample(STATUS_DRDY, -16'sd1, -16'sd1, -16'sd1);
        send_sample(8'h88, 16'sd0, 16'sd0, 16'sd0);
        send_sample(8'hf7, -16'sd1, 16'sd0, 16'sd1);

        // random: mostly fresh data, some status-only noise
        for (i = 0; i < N_RANDOM; i++) begin
            if (i == 300) begin
                // drain completely before carrying on
                in_valid <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
            if (i == 600) hold_req = 1'b1;
            gaps_on = !(i >= 900 && i < 1100);
            stalls_on = !(i >= 1000 && i < 1200);
            if ($urandom_range(0, 9) == 0)
                send_sample(8'($urandom) & ~(STATUS_DRDY | STATUS_OVR), rand_axis(),
                            rand_axis(), rand_axis());
            else
                send_sample(data_status(), rand_axis(), rand_axis(), rand_axis());
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("mag_minmax_calibrate_normalize_core: match");
        else
            $display("mag_minmax_calibrate_normalize_core: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
